// File: hw/rtl/hct_pkg.sv
// Package for the handheld console timer: item structs, command and
// register select codes, and the fixed countdown floors and rate divisors.
// Depends on nothing.
`default_nettype none

package hct_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  localparam logic [1:0] SEL_DIVIDER = 2'd0;
  localparam logic [1:0] SEL_TIMER   = 2'd1;
  localparam logic [1:0] SEL_RELOAD  = 2'd2;
  localparam logic [1:0] SEL_CONTROL = 2'd3;

  localparam int CTRL_ENABLE_BIT = 2;

  localparam int DIVCD_FLOOR = -512;
  localparam int TIMCD_FLOOR = -2048;

  localparam int RATE_DIV_0 = 4096;
  localparam int RATE_DIV_1 = 262144;
  localparam int RATE_DIV_2 = 65536;
  localparam int RATE_DIV_3 = 16384;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } out_t;

endpackage

`default_nettype wire

// File: hw/rtl/handheld_console_timer_top.sv
// Top level of the handheld console timer: divider, timer counter, reload
// value and control registers with their countdowns, plus an output skid stage.
// Depends on hct_pkg.
`default_nettype none

// The block takes one item (register read, register write or tick) in every
// clock cycle while in_stall is low, and gives exactly one result item for
// each. All of an item's work is a short add, compare and select on the state
// registers, so the state is updated in the cycle of acceptance. The result
// goes into an output register backed by a one-entry skid stage, so input
// is taken while a result waits; in_stall rises only when both are full.
module handheld_console_timer_top #(
  parameter int DIV_PERIOD = 256,
  parameter int CLOCK_RATE = 4194304
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire hct_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output hct_pkg::out_t     out_data
);

  localparam int DW_MIN = 10;
  localparam int DW_REQ = $clog2(DIV_PERIOD) + 1;
  localparam int DW     = (DW_REQ > DW_MIN) ? DW_REQ : DW_MIN;

  localparam int TP_MAX = CLOCK_RATE / hct_pkg::RATE_DIV_0;
  localparam int TW_MIN = 12;
  localparam int TW_REQ = $clog2(TP_MAX + 1) + 1;
  localparam int TW     = (TW_REQ > TW_MIN) ? TW_REQ : TW_MIN;

  localparam logic signed [DW:0] DIV_FLOOR = (DW+1)'(hct_pkg::DIVCD_FLOOR);
  localparam logic signed [DW:0] DIV_ADD   = (DW+1)'(DIV_PERIOD);
  localparam logic signed [TW:0] TIM_FLOOR = (TW+1)'(hct_pkg::TIMCD_FLOOR);
  localparam logic signed [TW:0] TP0 = (TW+1)'(CLOCK_RATE / hct_pkg::RATE_DIV_0);
  localparam logic signed [TW:0] TP1 = (TW+1)'(CLOCK_RATE / hct_pkg::RATE_DIV_1);
  localparam logic signed [TW:0] TP2 = (TW+1)'(CLOCK_RATE / hct_pkg::RATE_DIV_2);
  localparam logic signed [TW:0] TP3 = (TW+1)'(CLOCK_RATE / hct_pkg::RATE_DIV_3);

  logic [7:0]           divider_r, divider_nxt;
  logic [7:0]           timer_count_r, timer_count_nxt;
  logic [7:0]           reload_r, reload_nxt;
  logic [7:0]           control_r, control_nxt;
  logic signed [DW-1:0] div_cd_r, div_cd_nxt;
  logic signed [TW-1:0] tim_cd_r, tim_cd_nxt;

  logic                 out_valid_r;
  hct_pkg::out_t        out_data_r;
  logic                 skid_valid_r;
  hct_pkg::out_t        skid_data_r;

  logic                 accept;
  logic                 out_fire;
  hct_pkg::out_t        res;

  logic signed [DW:0]   div_diff;
  logic signed [DW:0]   div_sat;
  logic signed [TW:0]   tim_diff;
  logic signed [TW:0]   tim_sat;
  logic signed [TW:0]   tim_period;
  logic [7:0]           timer_inc;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid & ~skid_valid_r;
  assign out_fire  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    case (control_r[1:0])
      2'd0:    tim_period = TP0;
      2'd1:    tim_period = TP1;
      2'd2:    tim_period = TP2;
      default: tim_period = TP3;
    endcase
  end

  always_comb begin
    divider_nxt     = divider_r;
    timer_count_nxt = timer_count_r;
    reload_nxt      = reload_r;
    control_nxt     = control_r;
    div_cd_nxt      = div_cd_r;
    tim_cd_nxt      = tim_cd_r;
    res             = '0;

    div_diff  = {div_cd_r[DW-1], div_cd_r} - {{(DW+1-8){1'b0}}, in_data.tick_cycles};
    div_sat   = (div_diff < DIV_FLOOR) ? DIV_FLOOR : div_diff;
    tim_diff  = {tim_cd_r[TW-1], tim_cd_r} - {{(TW+1-8){1'b0}}, in_data.tick_cycles};
    tim_sat   = (tim_diff < TIM_FLOOR) ? TIM_FLOOR : tim_diff;
    timer_inc = timer_count_r + 8'd1;

    case (in_data.cmd)
      hct_pkg::CMD_READ: begin
        case (in_data.reg_select)
          hct_pkg::SEL_DIVIDER: res.read_data = divider_r;
          hct_pkg::SEL_TIMER:   res.read_data = timer_count_r;
          hct_pkg::SEL_RELOAD:  res.read_data = reload_r;
          default:              res.read_data = control_r;
        endcase
      end
      hct_pkg::CMD_WRITE: begin
        case (in_data.reg_select)
          hct_pkg::SEL_DIVIDER: divider_nxt     = 8'd0;
          hct_pkg::SEL_TIMER:   timer_count_nxt = in_data.write_data;
          hct_pkg::SEL_RELOAD:  reload_nxt      = in_data.write_data;
          default:              control_nxt     = in_data.write_data;
        endcase
      end
      hct_pkg::CMD_TICK: begin
        if (div_sat < 0) begin
          div_cd_nxt  = DW'(div_sat + DIV_ADD);
          divider_nxt = divider_r + 8'd1;
        end else begin
          div_cd_nxt = DW'(div_sat);
        end
        if (control_r[hct_pkg::CTRL_ENABLE_BIT]) begin
          if (tim_sat <= 0) begin
            tim_cd_nxt = TW'(tim_sat + tim_period);
            if (timer_inc == 8'd0) begin
              timer_count_nxt = reload_r;
              res.timer_irq   = 1'b1;
            end else begin
              timer_count_nxt = timer_inc;
            end
          end else begin
            tim_cd_nxt = TW'(tim_sat);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divider_r     <= '0;
      timer_count_r <= '0;
      reload_r      <= '0;
      control_r     <= '0;
      div_cd_r      <= '0;
      tim_cd_r      <= '0;
    end else if (accept) begin
      divider_r     <= divider_nxt;
      timer_count_r <= timer_count_nxt;
      reload_r      <= reload_nxt;
      control_r     <= control_nxt;
      div_cd_r      <= div_cd_nxt;
      tim_cd_r      <= tim_cd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_fire) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

endmodule

`default_nettype wire
